>>> hdl/eiph_pkg.sv
// ----------------------------------------------------------------------------
// eiph_pkg
// Shared types and constants of the Ethernet / IPv4 / L4 header parser.
// ----------------------------------------------------------------------------
package eiph_pkg;

  localparam int unsigned MaxFrameBytes   = 2048;
  localparam int unsigned IcmpHeaderBytes = 8;
  localparam int unsigned PosW            = $clog2(MaxFrameBytes + 1);

  localparam logic [15:0] ETYPE_IPV4 = 16'h0800;
  localparam logic [15:0] ETYPE_ARP  = 16'h0806;
  localparam logic [7:0]  PROTO_ICMP = 8'd1;
  localparam logic [7:0]  PROTO_TCP  = 8'd6;
  localparam logic [7:0]  PROTO_UDP  = 8'd17;

  typedef enum logic [2:0] {
    KIND_ETH  = 3'd0,
    KIND_IPV4 = 3'd1,
    KIND_ARP  = 3'd2,
    KIND_ICMP = 3'd3,
    KIND_TCP  = 3'd4,
    KIND_UDP  = 3'd5,
    KIND_ERR  = 3'd6
  } kind_t;

  // one result word
  typedef struct packed {
    logic        last_result;
    logic [1:0]  header_count;
    logic [31:0] field_two;
    logic [31:0] field_one;
    logic [11:0] payload_length;
    logic [10:0] payload_offset;
    logic [10:0] header_offset;
    kind_t       header_kind;
    logic [1:0]  header_level;
  } result_t;

  // snapshot of a finished frame
  typedef struct packed {
    logic [PosW-1:0] len;
    logic [15:0]     ether_type;
    logic [3:0]      ihl;
    logic [15:0]     total_len;
    logic [7:0]      proto;
    logic [31:0]     src;
    logic [31:0]     dst;
    logic [63:0]     arp;
    logic [31:0]     word_a;
    logic [31:0]     word_b;
    logic [3:0]      doff;
  } frame_t;

  localparam int unsigned QDepth = 2;

endpackage

>>> hdl/eiph_capture.sv
// ----------------------------------------------------------------------------
// eiph_capture
// Front end: counts frame bytes and latches header fields as they pass.
// ----------------------------------------------------------------------------
module eiph_capture import eiph_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_fire,
  input  logic [7:0] byte_value,
  input  logic       last_byte,
  output logic       frame_done,
  output frame_t     frame
);

  logic [PosW-1:0] pos_r, pos_nxt;
  frame_t          f_r, f_nxt;
  logic [PosW-1:0] t;

  always_comb begin
    f_nxt      = f_r;
    pos_nxt    = pos_r;
    t          = PosW'(14) + {f_r.ihl, 2'b00};
    frame_done = in_fire && last_byte;
    frame      = f_r;
    if (in_fire && pos_r < PosW'(MaxFrameBytes)) begin
      pos_nxt = pos_r + 1'b1;
      if (pos_r == 12 || pos_r == 13) f_nxt.ether_type = {f_r.ether_type[7:0], byte_value};
      if (pos_r == 14) f_nxt.ihl = byte_value[3:0];
      if (pos_r >= 14 && pos_r <= 21) f_nxt.arp = {f_r.arp[55:0], byte_value};
      if (pos_r == 16 || pos_r == 17) f_nxt.total_len = {f_r.total_len[7:0], byte_value};
      if (pos_r == 23) f_nxt.proto = byte_value;
      if (pos_r >= 26 && pos_r <= 29) f_nxt.src = {f_r.src[23:0], byte_value};
      if (pos_r >= 30 && pos_r <= 33) f_nxt.dst = {f_r.dst[23:0], byte_value};
      if (pos_r > 14) begin
        if (pos_r >= t && pos_r < t + 4) f_nxt.word_a = {f_r.word_a[23:0], byte_value};
        else if (pos_r >= t + 4 && pos_r < t + 8)
          f_nxt.word_b = {f_r.word_b[23:0], byte_value};
        else if (pos_r == t + 12) f_nxt.doff = byte_value[7:4];
      end
    end
    f_nxt.len = pos_nxt;
    frame     = f_nxt;
    if (frame_done) begin
      f_nxt   = '0;
      pos_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      f_r   <= '0;
    end else begin
      pos_r <= pos_nxt;
      f_r   <= f_nxt;
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n) frame_done |=> pos_r == '0)
    else $error("position not cleared after frame");
  assert property (@(posedge clk) disable iff (!rst_n) pos_r <= PosW'(MaxFrameBytes))
    else $error("position beyond frame limit");
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && !last_byte && pos_r < PosW'(MaxFrameBytes)) |=> pos_r == $past(pos_r) + 1'b1)
    else $error("position did not advance");

endmodule

>>> hdl/eiph_queue.sv
// ----------------------------------------------------------------------------
// eiph_queue
// Short queue of finished frame snapshots between front and back end.
// ----------------------------------------------------------------------------
module eiph_queue import eiph_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push,
  input  frame_t push_data,
  output logic   can_push,
  input  logic   pop,
  output logic   not_empty,
  output frame_t head
);

  frame_t      mem_r [QDepth];
  logic        wp_r, rp_r;
  logic [1:0]  cnt_r;

  assign can_push  = cnt_r != 2'(QDepth);
  assign not_empty = cnt_r != '0;
  assign head      = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n) push |-> can_push)
    else $error("queue overflow");
  assert property (@(posedge clk) disable iff (!rst_n) pop |-> not_empty)
    else $error("queue underflow");
  assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= 2'(QDepth))
    else $error("queue count out of range");

endmodule

>>> hdl/eiph_emit.sv
// ----------------------------------------------------------------------------
// eiph_emit
// Back end: classifies a frame snapshot and issues one result per layer, none under 14 bytes.
// ----------------------------------------------------------------------------
module eiph_emit import eiph_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    not_empty,
  input  frame_t  head,
  output logic    pop,
  output logic    out_tvalid,
  input  logic    out_tready,
  output result_t res
);

  logic [1:0]  idx_r, idx_nxt;
  logic        vld_r;
  result_t     res_r;
  result_t     r [3];
  logic [1:0]  cnt;
  logic [11:0] rest, l4, hl, tl, t, pl_tcp;
  logic [15:0] a;
  logic        none, take, load;

  always_comb begin
    rest = 12'(head.len) - 12'd14;
    hl   = {6'd0, head.ihl, 2'b00};
    tl   = {6'd0, head.doff, 2'b00};
    t    = 12'd14 + hl;
    l4   = rest - hl;
    // total length minus both headers, clamped, then cut to the field width
    a    = (head.total_len > 16'(hl)) ? head.total_len - 16'(hl) : 16'd0;
    pl_tcp = (a > 16'(tl)) ? 12'(a - 16'(tl)) : 12'd0;
    none = head.len < PosW'(14);
    for (int i = 0; i < 3; i++) r[i] = '0;
    r[0].header_kind    = KIND_ETH;
    r[0].payload_offset = 11'd14;
    r[0].payload_length = rest;
    r[0].field_one      = {16'd0, head.ether_type};
    r[1].header_level   = 2'd1;
    r[1].header_kind    = KIND_ERR;
    r[1].header_offset  = 11'd14;
    r[2].header_level   = 2'd2;
    r[2].header_offset  = t[10:0];
    cnt = 2'd2;
    if (head.ether_type == ETYPE_IPV4) begin
      if (!(rest < 12'd20 || head.ihl < 4'd5 || rest < hl)) begin
        r[1].header_kind    = KIND_IPV4;
        r[1].payload_offset = t[10:0];
        r[1].payload_length = l4;
        r[1].field_one      = head.src;
        r[1].field_two      = head.dst;
        if (head.proto == PROTO_ICMP) begin
          if (l4 >= 12'(IcmpHeaderBytes)) begin
            r[2].header_kind    = KIND_ICMP;
            r[2].payload_offset = 11'(t + 12'(IcmpHeaderBytes));
            r[2].payload_length = l4 - 12'(IcmpHeaderBytes);
            r[2].field_one      = {16'd0, head.word_a[31:16]};
            r[2].field_two      = {16'd0, head.word_a[15:0]};
            cnt = 2'd3;
          end
        end else if (head.proto == PROTO_TCP) begin
          if (l4 >= 12'd20 && head.doff >= 4'd5 && l4 >= tl) begin
            r[2].header_kind    = KIND_TCP;
            r[2].payload_offset = 11'(t + tl);
            r[2].payload_length = pl_tcp;
            r[2].field_one      = head.word_a;
            r[2].field_two      = head.word_b;
            cnt = 2'd3;
          end
        end else if (head.proto == PROTO_UDP) begin
          if (l4 >= 12'd8) begin
            r[2].header_kind    = KIND_UDP;
            r[2].payload_offset = 11'(t + 12'd8);
            r[2].payload_length = (head.word_b[31:16] > 16'd8) ?
                                  12'(head.word_b[31:16] - 16'd8) : 12'd0;
            r[2].field_one      = head.word_a;
            r[2].field_two      = {16'd0, head.word_b[31:16]};
            cnt = 2'd3;
          end
        end else begin
          r[2].header_kind = KIND_ERR;
          cnt = 2'd3;
        end
      end
    end else if (head.ether_type == ETYPE_ARP) begin
      if (!(rest < 12'd8 ||
            {1'b0, rest} < 13'd8 + {4'd0, head.arp[31:24], 1'b0}
                               + {4'd0, head.arp[23:16], 1'b0})) begin
        r[1].header_kind = KIND_ARP;
        r[1].field_one   = {16'd0, head.arp[15:0]};
        r[1].field_two   = head.arp[63:32];
      end
    end
    for (int i = 0; i < 3; i++) begin
      r[i].header_count = cnt;
      r[i].last_result  = (2'(i) == cnt - 2'd1);
    end
    take    = !vld_r || out_tready;
    load    = take && not_empty;
    pop     = load && (none || idx_r == cnt - 2'd1);
    idx_nxt = idx_r;
    if (load) idx_nxt = pop ? 2'd0 : idx_r + 2'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
      idx_r <= '0;
    end else begin
      idx_r <= idx_nxt;
      if (take) vld_r <= load && !none;
    end
  end

  always_ff @(posedge clk) begin
    if (load) res_r <= r[idx_r];
  end

  assign out_tvalid = vld_r;
  assign res        = res_r;

  assert property (@(posedge clk) disable iff (!rst_n) idx_r != 2'd3)
    else $error("result index out of range");
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && res.last_result) |-> res.header_count == res.header_level + 2'd1)
    else $error("last result level mismatch");
  assert property (@(posedge clk) disable iff (!rst_n) pop |=> idx_r == 2'd0)
    else $error("index not rewound");

endmodule

>>> hdl/eth_ip_l4_header_parser.sv
// ----------------------------------------------------------------------------
// eth_ip_l4_header_parser
// Streaming Ethernet / IPv4 / ARP / ICMP / TCP / UDP header parser.
// ----------------------------------------------------------------------------
// accepts one frame byte per cycle; fields are captured as bytes pass
// each frame is queued and its results are registered, one per cycle while
// out_tready is high (none under 14 bytes, else two or three per frame); a two-deep
// frame queue decouples capture from output, so input stalls only when both slots wait
// synchronous active-low reset clears counters, captured fields and queue
module eth_ip_l4_header_parser import eiph_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,   // byte_value
  input  logic         in_tlast,   // last_byte
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [103:0] out_tdata,  // header_offset, payload_offset, payload_length,
                                   // field_one, field_two, header_count
  output logic [4:0]   out_tuser,  // header_level, header_kind
  output logic         out_tlast   // last_result
);

  logic    in_fire, frame_done, can_push, pop, not_empty;
  frame_t  frame, head;
  result_t res;

  assign in_tready = can_push;
  assign in_fire   = in_tvalid && in_tready;

  eiph_capture u_cap (
    .clk, .rst_n, .in_fire,
    .byte_value(in_tdata), .last_byte(in_tlast),
    .frame_done, .frame
  );

  eiph_queue u_q (
    .clk, .rst_n, .push(frame_done), .push_data(frame), .can_push,
    .pop, .not_empty, .head
  );

  eiph_emit u_emit (
    .clk, .rst_n, .not_empty, .head, .pop, .out_tvalid, .out_tready, .res
  );

  assign out_tdata = {4'd0, res.header_count, res.field_two, res.field_one,
                      res.payload_length, res.payload_offset, res.header_offset};
  assign out_tuser = {res.header_kind, res.header_level};
  assign out_tlast = res.last_result;

endmodule
